// ===== design/v2dxc_pkg.sv =====
package v2dxc_pkg;

    localparam int PIX_W       = 16;
    localparam int PROD_W      = 32;
    localparam int SUM_W       = 40;
    localparam int ROW_W       = 12;
    localparam int OCOL_W      = 10;
    localparam int COL_W       = 12;
    localparam int IDX_W       = 5;
    localparam int DIM_W       = 13;
    localparam int KDIM_W      = 3;
    localparam int MAX_HEIGHT  = 4096;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;
    localparam int MID_DEPTH   = 4;
    localparam int OUT_DEPTH   = 8;
    localparam int OUT_LVL_W   = $clog2(OUT_DEPTH + 1);

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_ROWS  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_COLS  = 3'd3;

    localparam logic FUNC_COEFF = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    typedef struct packed {
        logic                    func;
        logic [IDX_W-1:0]        coeff_index;
        logic signed [PIX_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] window_sum;
        logic [ROW_W-1:0]        out_row;
        logic [OCOL_W-1:0]       out_col;
        logic                    last_of_frame;
    } result_t;

    typedef struct packed {
        logic                    is_pixel;
        logic [IDX_W-1:0]        coeff_index;
        logic signed [PIX_W-1:0] value;
        logic [COL_W-1:0]        col;
        logic                    emit;
        logic [ROW_W-1:0]        out_row;
        logic [OCOL_W-1:0]       out_col;
        logic                    last;
    } work_t;

    typedef struct packed {
        logic [KDIM_W-1:0] rows;
        logic [KDIM_W-1:0] cols;
    } kdim_t;

endpackage

// ===== design/v2dxc_ram.sv =====
module v2dxc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/v2dxc_fifo.sv =====
module v2dxc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [WIDTH-1:0]             wr_data,
    output logic                         full,
    input  logic                         rd_en,
    output logic [WIDTH-1:0]             rd_data,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   level
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [LW-1:0]    level_reg, level_next;
    logic             do_wr, do_rd;

    assign full  = (level_reg == LW'(DEPTH));
    assign empty = (level_reg == '0);
    assign level = level_reg;
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        level_next = level_reg + LW'(do_wr) - LW'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== design/v2dxc_front.sv =====
module v2dxc_front import v2dxc_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 5
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   push,
    input  item_t                  item,
    input  logic                   q_full,
    output logic                   q_push,
    output work_t                  q_data,
    output kdim_t                  kdim
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam logic [KDIM_W-1:0] KMAX = KDIM_W'(MAX_KERNEL);

    logic [10:0]        width_reg, width_next;
    logic [12:0]        height_reg, height_next;
    logic [KDIM_W-1:0]  krows_reg, krows_next;
    logic [KDIM_W-1:0]  kcols_reg, kcols_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [AW-1:0]      col_reg, col_next;

    logic [DIM_W-1:0]   w_eff, h_eff, row_p1, col_p1, r0, c0;
    logic [KDIM_W-1:0]  kr_eff, kc_eff;
    logic               col_end, row_end, cfg_hit, is_pixel;

    assign cfg_ready = 1'b1;
    assign q_push    = push && !q_full;
    assign is_pixel  = (item.func == FUNC_PIXEL);

    // clamp the dimension registers to their legal ranges
    always_comb
    begin
        if (width_reg == '0)
            w_eff = DIM_W'(1);
        else if (DIM_W'(width_reg) > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = DIM_W'(width_reg);

        if (height_reg == '0)
            h_eff = DIM_W'(1);
        else if (DIM_W'(height_reg) > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = DIM_W'(height_reg);

        if (krows_reg == '0)
            kr_eff = KDIM_W'(1);
        else if (krows_reg > KMAX)
            kr_eff = KMAX;
        else
            kr_eff = krows_reg;

        if (kcols_reg == '0)
            kc_eff = KDIM_W'(1);
        else if (kcols_reg > KMAX)
            kc_eff = KMAX;
        else
            kc_eff = kcols_reg;
    end

    assign kdim.rows = kr_eff;
    assign kdim.cols = kc_eff;

    assign row_p1  = DIM_W'(row_reg) + DIM_W'(1);
    assign col_p1  = DIM_W'(col_reg) + DIM_W'(1);
    assign col_end = (col_p1 >= w_eff);
    assign row_end = (row_p1 >= h_eff);
    assign r0      = row_p1 - DIM_W'(kr_eff);
    assign c0      = col_p1 - DIM_W'(kc_eff);

    always_comb
    begin
        q_data.is_pixel    = is_pixel;
        q_data.coeff_index = item.coeff_index;
        q_data.value       = item.value;
        q_data.col         = COL_W'(col_reg);
        q_data.emit        = (row_p1 >= DIM_W'(kr_eff)) && (col_p1 >= DIM_W'(kc_eff));
        q_data.out_row     = r0[ROW_W-1:0];
        q_data.out_col     = c0[OCOL_W-1:0];
        q_data.last        = row_end && col_end;
    end

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        krows_next  = krows_reg;
        kcols_next  = kcols_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        cfg_hit     = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:
                begin
                    width_next = cfg_data[10:0];
                    cfg_hit    = 1'b1;
                end
                CFG_IMAGE_HEIGHT:
                begin
                    height_next = cfg_data[12:0];
                    cfg_hit     = 1'b1;
                end
                CFG_KERNEL_ROWS:
                begin
                    krows_next = cfg_data[KDIM_W-1:0];
                    cfg_hit    = 1'b1;
                end
                CFG_KERNEL_COLS:
                begin
                    kcols_next = cfg_data[KDIM_W-1:0];
                    cfg_hit    = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end

        // a register write restarts the frame
        if (cfg_hit)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (q_push && is_pixel)
        begin
            if (col_end)
            begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd1024;
            height_reg <= 13'd1024;
            krows_reg  <= 3'd3;
            kcols_reg  <= 3'd3;
            row_reg    <= '0;
            col_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            krows_reg  <= krows_next;
            kcols_reg  <= kcols_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
        end
    end

endmodule

// ===== design/v2dxc_back.sv =====
module v2dxc_back import v2dxc_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  work_t                q_head,
    output logic                 q_pop,
    input  kdim_t                kdim,
    input  logic [OUT_LVL_W-1:0] res_level,
    output logic                 res_push,
    output result_t              res_data
);

    localparam int K    = MAX_KERNEL;
    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int LB   = K - 1;
    localparam int LBW  = ((LB > 0) ? LB : 1) * PIX_W;
    localparam int RS_W = PROD_W + $clog2(K);

    logic                     s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    work_t                    s1_item_reg, s2_item_reg, s3_item_reg, s4_item_reg;
    logic                     s1_fwd_reg;
    logic [LBW-1:0]           s1_fwd_data_reg;

    logic [LBW-1:0]           ram_rdata, line_rd, line_wdata;
    logic signed [PIX_W-1:0]  colv [K];
    logic signed [PIX_W-1:0]  win_reg [K][K];
    logic signed [PIX_W-1:0]  kern_reg [K][K];
    logic signed [PIX_W-1:0]  acoef [K][K];
    logic signed [PROD_W-1:0] prod_reg [K][K];
    logic signed [RS_W-1:0]   rsum_next [K];
    logic signed [RS_W-1:0]   rsum_reg [K];
    logic signed [SUM_W-1:0]  total;

    logic [2:0]               inflight;
    logic [OUT_LVL_W:0]       used;
    logic                     credit_ok, head_emit, fwd_hit;

    // output credit: results in flight plus results waiting must fit the output queue
    assign inflight = 3'($countones({s1_valid_reg && s1_item_reg.is_pixel && s1_item_reg.emit,
                                     s2_valid_reg && s2_item_reg.is_pixel && s2_item_reg.emit,
                                     s3_valid_reg && s3_item_reg.is_pixel && s3_item_reg.emit,
                                     s4_valid_reg && s4_item_reg.is_pixel && s4_item_reg.emit}));
    assign used      = {1'b0, res_level} + (OUT_LVL_W+1)'(inflight);
    assign credit_ok = (used < (OUT_LVL_W+1)'(OUT_DEPTH));
    assign head_emit = q_head.is_pixel && q_head.emit;
    assign q_pop     = !q_empty && (!head_emit || credit_ok);

    // line buffer write in stage 1 may hit the address read by the next beat
    assign fwd_hit = s1_valid_reg && s1_item_reg.is_pixel && (s1_item_reg.col == q_head.col);
    assign line_rd = s1_fwd_reg ? s1_fwd_data_reg : ram_rdata;

    always_comb
    begin
        line_wdata = '0;
        for (int k = 0; k < LB; k++)
        begin
            if (k == 0)
                line_wdata[k*PIX_W +: PIX_W] = s1_item_reg.value;
            else
                line_wdata[k*PIX_W +: PIX_W] = line_rd[(k-1)*PIX_W +: PIX_W];
        end
    end

    always_comb
    begin
        for (int k = 0; k < K; k++)
        begin
            if (k == 0)
                colv[k] = s1_item_reg.value;
            else
                colv[k] = line_rd[(k-1)*PIX_W +: PIX_W];
        end
    end

    generate
        if (LB > 0)
        begin : g_line
            v2dxc_ram #(
                .WIDTH (LBW),
                .DEPTH (MAX_WIDTH)
            ) u_line_ram (
                .clk   (clk),
                .we    (s1_valid_reg && s1_item_reg.is_pixel),
                .waddr (s1_item_reg.col[AW-1:0]),
                .wdata (line_wdata),
                .re    (q_pop),
                .raddr (q_head.col[AW-1:0]),
                .rdata (ram_rdata)
            );
        end
        else
        begin : g_noline
            assign ram_rdata = '0;
        end
    endgenerate

    // coefficient aligned to window offset (dr, dc) from the newest pixel
    always_comb
    begin
        for (int dr = 0; dr < K; dr++)
        begin
            for (int dc = 0; dc < K; dc++)
            begin
                acoef[dr][dc] = '0;
                for (int i = 0; i < K; i++)
                begin
                    for (int j = 0; j < K; j++)
                    begin
                        if ((4'(i + dr + 1) == {1'b0, kdim.rows}) &&
                            (4'(j + dc + 1) == {1'b0, kdim.cols}))
                        begin
                            acoef[dr][dc] = kern_reg[i][j];
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int dr = 0; dr < K; dr++)
        begin
            rsum_next[dr] = '0;
            for (int dc = 0; dc < K; dc++)
            begin
                rsum_next[dr] = rsum_next[dr] + RS_W'(prod_reg[dr][dc]);
            end
        end
    end

    always_comb
    begin
        total = '0;
        for (int dr = 0; dr < K; dr++)
        begin
            total = total + SUM_W'(rsum_reg[dr]);
        end
    end

    assign res_push               = s4_valid_reg && s4_item_reg.is_pixel && s4_item_reg.emit;
    assign res_data.window_sum    = total;
    assign res_data.out_row       = s4_item_reg.out_row;
    assign res_data.out_col       = s4_item_reg.out_col;
    assign res_data.last_of_frame = s4_item_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= q_pop;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // sliding window, newest column at offset zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < K; k++)
            begin
                for (int j = 0; j < K; j++)
                begin
                    win_reg[k][j] <= '0;
                end
            end
        end
        else if (s1_valid_reg && s1_item_reg.is_pixel)
        begin
            for (int k = 0; k < K; k++)
            begin
                win_reg[k][0] <= colv[k];
                for (int j = 1; j < K; j++)
                begin
                    win_reg[k][j] <= win_reg[k][j-1];
                end
            end
        end
    end

    // coefficient beats update the kernel in order with the pixels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < K; i++)
            begin
                for (int j = 0; j < K; j++)
                begin
                    kern_reg[i][j] <= '0;
                end
            end
        end
        else if (s2_valid_reg && !s2_item_reg.is_pixel)
        begin
            for (int i = 0; i < K; i++)
            begin
                for (int j = 0; j < K; j++)
                begin
                    if ({1'b0, s2_item_reg.coeff_index} == (IDX_W+1)'(i * K + j))
                    begin
                        kern_reg[i][j] <= s2_item_reg.value;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_item_reg     <= q_head;
            s1_fwd_reg      <= fwd_hit;
            s1_fwd_data_reg <= line_wdata;
        end
        s2_item_reg <= s1_item_reg;
        s3_item_reg <= s2_item_reg;
        s4_item_reg <= s3_item_reg;
        if (s2_valid_reg)
        begin
            for (int dr = 0; dr < K; dr++)
            begin
                for (int dc = 0; dc < K; dc++)
                begin
                    // taps outside the kernel in use hold rows of no interest
                    if ((KDIM_W'(dr) < kdim.rows) && (KDIM_W'(dc) < kdim.cols))
                        prod_reg[dr][dc] <= win_reg[dr][dc] * acoef[dr][dc];
                    else
                        prod_reg[dr][dc] <= '0;
                end
            end
        end
        if (s3_valid_reg)
        begin
            for (int dr = 0; dr < K; dr++)
            begin
                rsum_reg[dr] <= rsum_next[dr];
            end
        end
    end

endmodule

// ===== design/valid_2d_cross_correlation.sv =====
// valid 2d cross-correlation over a raster-order pixel stream
// input side is a queue: drive item and push while full is low; func 0 beats
// load one kernel coefficient, func 1 beats are pixels of the current frame
// output side is a queue: while empty is low the oldest result is on result,
// pop takes it; each result carries its window sum and output row/column
// configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, written while
// the block is idle; any write to a known register restarts the frame
// throughput: one beat per cycle, coefficient or pixel, while full is low
// path: an accepted pixel beat passes through the input queue, line buffer read,
// window, multiplier and row-sum stages; the final sum is written straight into
// the output queue
// when pop is held low, results collect in an 8-entry output queue; the
// back end stops issuing windows once results waiting plus results in flight
// reach 8, and the 4-entry input queue then raises full
// reset: kernel cleared to zero, dimensions 1024 x 1024 with a 3 x 3 kernel,
// frame position at row 0 column 0, both queues empty
module valid_2d_cross_correlation import v2dxc_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_KERNEL = 5
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   push,
    input  item_t                  item,
    output logic                   full,
    output logic                   empty,
    input  logic                   pop,
    output result_t                result
);

    logic                 q_push, q_empty, q_pop;
    work_t                q_data, q_head;
    kdim_t                kdim;
    logic                 res_push;
    result_t              res_data;
    logic [OUT_LVL_W-1:0] res_level;

    v2dxc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .item      (item),
        .q_full    (full),
        .q_push    (q_push),
        .q_data    (q_data),
        .kdim      (kdim)
    );

    v2dxc_fifo #(
        .WIDTH ($bits(work_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_data),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .empty   (q_empty),
        .level   ()
    );

    v2dxc_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .kdim      (kdim),
        .res_level (res_level),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    v2dxc_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_data),
        .full    (),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty),
        .level   (res_level)
    );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench import v2dxc_pkg::*; ();

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_KERNEL   = 5;
    localparam int KSIZE        = MAX_KERNEL * MAX_KERNEL;
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 300;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   push;
    item_t                  item;
    logic                   full;
    logic                   empty;
    logic                   pop;
    result_t                result;

    // predictor state
    logic signed [PIX_W-1:0] line_mem [MAX_KERNEL][MAX_WIDTH];
    logic signed [PIX_W-1:0] coef_mem [KSIZE];
    logic [10:0]             reg_width;
    logic [12:0]             reg_height;
    logic [KDIM_W-1:0]       reg_krows;
    logic [KDIM_W-1:0]       reg_kcols;
    int unsigned             row_pos;
    int unsigned             col_pos;

    result_t expected_windows [$];
    int      error_count;
    int      cycle_count;
    bit      idle_on;
    int      hold_cycles;

    valid_2d_cross_correlation #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .item      (item),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic signed [PIX_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return '0;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic item_t make_pixel(logic signed [PIX_W-1:0] v);
        item_t it;
        it.func        = FUNC_PIXEL;
        it.coeff_index = IDX_W'($urandom);
        it.value       = v;
        return it;
    endfunction

    function automatic item_t make_coeff(int unsigned idx, logic signed [PIX_W-1:0] v);
        item_t it;
        it.func        = FUNC_COEFF;
        it.coeff_index = IDX_W'(idx);
        it.value       = v;
        return it;
    endfunction

    task automatic clear_predictor();
        for (int r = 0; r < MAX_KERNEL; r++)
            for (int c = 0; c < MAX_WIDTH; c++)
                line_mem[r][c] = '0;
        for (int k = 0; k < KSIZE; k++)
            coef_mem[k] = '0;
        reg_width  = 11'd1024;
        reg_height = 13'd1024;
        reg_krows  = 3'd3;
        reg_kcols  = 3'd3;
        row_pos    = 0;
        col_pos    = 0;
    endtask

    task automatic apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        bit known;
        known = 1'b1;
        case (idx)
            CFG_IMAGE_WIDTH:  reg_width  = data[10:0];
            CFG_IMAGE_HEIGHT: reg_height = data[12:0];
            CFG_KERNEL_ROWS:  reg_krows  = data[KDIM_W-1:0];
            CFG_KERNEL_COLS:  reg_kcols  = data[KDIM_W-1:0];
            default:          known = 1'b0;
        endcase
        if (known)
        begin
            row_pos = 0;
            col_pos = 0;
        end
    endtask

    task automatic correlate_item(item_t it);
        int unsigned w, h, kr, kc, r, c, r0, c0;
        longint      acc;
        result_t     res;
        w  = clamp_dim(reg_width, MAX_WIDTH);
        h  = clamp_dim(reg_height, MAX_HEIGHT);
        kr = clamp_dim(reg_krows, MAX_KERNEL);
        kc = clamp_dim(reg_kcols, MAX_KERNEL);
        if (it.func == FUNC_COEFF)
        begin
            if (it.coeff_index < KSIZE)
                coef_mem[it.coeff_index] = it.value;
            return;
        end
        r = row_pos;
        c = col_pos;
        if (c >= MAX_WIDTH)
            c = MAX_WIDTH - 1;
        line_mem[r % MAX_KERNEL][c] = it.value;
        if (r + 1 >= kr && c + 1 >= kc)
        begin
            r0  = r + 1 - kr;
            c0  = c + 1 - kc;
            acc = 0;
            for (int k = 0; k < kr; k++)
                for (int l = 0; l < kc; l++)
                    acc += longint'(line_mem[(r0 + k) % MAX_KERNEL][c0 + l])
                         * longint'(coef_mem[k * MAX_KERNEL + l]);
            res.window_sum    = acc[SUM_W-1:0];
            res.out_row       = r0[ROW_W-1:0];
            res.out_col       = c0[OCOL_W-1:0];
            res.last_of_frame = (r + 1 >= h) && (c + 1 >= w);
            expected_windows.push_back(res);
        end
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            col_pos = c + 1;
    endtask

    // sender: returns at the rising edge that took the beat
    task automatic send_item(item_t it);
        int gap;
        gap = 0;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 16);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (full);
        correlate_item(it);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(int unsigned w, int unsigned h, int unsigned kr, int unsigned kc);
        write_reg(CFG_IMAGE_WIDTH,  CFG_DATA_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_KERNEL_ROWS,  CFG_DATA_W'(kr));
        write_reg(CFG_KERNEL_COLS,  CFG_DATA_W'(kc));
    endtask

    task automatic drain_block();
        @(negedge clk);
        push <= 1'b0;
        while (expected_windows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_pixels(int n);
        for (int i = 0; i < n; i++)
            send_item(make_pixel(rand_value()));
    endtask

    task automatic test_directed();
        drain_block();
        configure(3, 3, 2, 2);
        send_item(make_coeff(0, -16'sd32768));
        send_item(make_coeff(1, 16'sd32767));
        send_item(make_coeff(5, -16'sd1));
        send_item(make_coeff(6, 16'sd1));
        send_item(make_coeff(16, -16'sd2));
        send_item(make_coeff(24, 16'sd5));
        // out-of-range coefficient positions are dropped
        send_item(make_coeff(25, 16'sd1234));
        send_item(make_coeff(31, -16'sd1));
        send_item(make_pixel(-16'sd32768));
        send_item(make_pixel(16'sd32767));
        send_item(make_pixel(16'sd0));
        send_item(make_pixel(-16'sd1));
        send_item(make_pixel(16'sd1));
        send_item(make_pixel(-16'sd32768));
        send_item(make_pixel(16'sd32767));
        send_item(make_pixel(16'sh5555));
        send_item(make_pixel(16'shAAAA));
    endtask

    task automatic test_register_limits();
        logic [CFG_DATA_W-1:0] data;
        // zero dimensions act as one
        drain_block();
        configure(0, 0, 0, 0);
        send_pixels(3);
        // oversized kernel clamps to 5x5, full-scale sums
        drain_block();
        configure(5, 5, 7, 7);
        for (int k = 0; k < KSIZE; k++)
            send_item(make_coeff(k, -16'sd32768));
        for (int i = 0; i < KSIZE; i++)
            send_item(make_pixel(-16'sd32768));
        for (int k = 0; k < KSIZE; k++)
            send_item(make_coeff(k, 16'sd32767));
        for (int i = 0; i < KSIZE; i++)
            send_item(make_pixel(-16'sd32768));
        // a known register write restarts the frame, spare indexes do not
        drain_block();
        configure(4, 4, 2, 2);
        send_pixels(6);
        drain_block();
        for (int i = CFG_SPARE_LO; i <= CFG_SPARE_HI; i++)
        begin
            data = CFG_DATA_W'($urandom);
            write_reg(CFG_INDEX_W'(i), data);
        end
        send_pixels(4);
        drain_block();
        write_reg(CFG_KERNEL_ROWS, CFG_DATA_W'(2));
        send_pixels(16);
    endtask

    task automatic test_kernel_exceeds_image();
        drain_block();
        configure(2, 3, 4, 2);
        send_pixels(15);
        drain_block();
        configure(3, 5, 1, 5);
        send_pixels(20);
    endtask

    task automatic test_backpressure();
        drain_block();
        configure(8, 8, 1, 1);
        send_item(make_coeff(0, rand_value()));
        hold_cycles = HOLD_CYCLES;
        send_pixels(64);
    endtask

    task automatic test_wide_row();
        drain_block();
        // width above the maximum clamps to a full line
        configure(2047, 1, 1, 1);
        send_item(make_coeff(0, rand_value()));
        send_pixels(MAX_WIDTH);
    endtask

    task automatic test_tall_column();
        drain_block();
        configure(1, 8191, 1, 1);
        send_item(make_coeff(0, rand_value()));
        send_pixels(32);
    endtask

    task automatic test_random_frames(int phases, int items_per_phase);
        logic [CFG_DATA_W-1:0] data;
        int                    sel;
        for (int p = 0; p < phases; p++)
        begin
            drain_block();
            if (p >= phases - 3)
                idle_on = 1'b0;
            data = CFG_DATA_W'($urandom);
            data[10:0] = 11'(($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                         : $urandom_range(0, 16));
            write_reg(CFG_IMAGE_WIDTH, data);
            data = CFG_DATA_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191)
                                                           : $urandom_range(0, 12));
            write_reg(CFG_IMAGE_HEIGHT, data);
            data = CFG_DATA_W'($urandom);
            write_reg(CFG_KERNEL_ROWS, data);
            data = CFG_DATA_W'($urandom);
            write_reg(CFG_KERNEL_COLS, data);
            for (int k = 0; k < KSIZE; k++)
                send_item(make_coeff(k, rand_value()));
            for (int n = 0; n < items_per_phase; n++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 4)
                    send_item(make_coeff($urandom_range(KSIZE, 31), rand_value()));
                else if (sel < 10)
                    send_item(make_coeff($urandom_range(0, KSIZE - 1), rand_value()));
                else
                    send_item(make_pixel(rand_value()));
            end
        end
    endtask

    // receiver
    initial
    begin
        int stall_left;
        stall_left = 0;
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles = hold_cycles - 1;
                pop <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                pop <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 16) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_windows.size() == 0)
            begin
                $display("%0t: unexpected beat, actual sum %0d row %0d col %0d last %0b",
                         $time, result.window_sum, result.out_row, result.out_col,
                         result.last_of_frame);
                error_count++;
            end
            else
            begin
                want = expected_windows.pop_front();
                if (result.window_sum !== want.window_sum)
                begin
                    $display("%0t: window_sum expected %0d actual %0d",
                             $time, want.window_sum, result.window_sum);
                    error_count++;
                end
                if (result.out_row !== want.out_row)
                begin
                    $display("%0t: out_row expected %0d actual %0d",
                             $time, want.out_row, result.out_row);
                    error_count++;
                end
                if (result.out_col !== want.out_col)
                begin
                    $display("%0t: out_col expected %0d actual %0d",
                             $time, want.out_col, result.out_col);
                    error_count++;
                end
                if (result.last_of_frame !== want.last_of_frame)
                begin
                    $display("%0t: last_of_frame expected %0b actual %0b",
                             $time, want.last_of_frame, result.last_of_frame);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        push        = 1'b0;
        item        = '0;
        error_count = 0;
        cycle_count = 0;
        idle_on     = 1'b1;
        hold_cycles = 0;
        clear_predictor();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_register_limits();
        test_kernel_exceeds_image();
        test_backpressure();
        test_wide_row();
        test_tall_column();
        test_random_frames(6, 20);

        drain_block();
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
